// ===== design/spi_encoder_reader_unwrap_core_macros.svh =====
// Assertion macros for the SPI encoder reader core.
// Taken in by the top level, which supplies i_clk and i_rst_n by name.
`ifndef SPI_ENCODER_READER_UNWRAP_CORE_MACROS_SVH
`define SPI_ENCODER_READER_UNWRAP_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPIENC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPIENC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/spienc_pkg.sv =====
// Shared constants and types for the SPI encoder reader core.
// No dependencies; used by spienc_unwrap and spi_encoder_reader_unwrap_core.
`default_nettype none

package spienc_pkg;

    // Default number of encoder channels.
    localparam int CHANNELS_DEF = 3;

    // Configuration register indexes and reset values.
    localparam int                CFG_IDX_W        = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TIMEOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TIMEOUT = 8'd1;
    localparam logic [15:0]       READ_TIMEOUT_RST = 16'd50;
    localparam logic [15:0]       ZERO_TIMEOUT_RST = 16'd1000;

    // Input command codes.
    localparam logic [1:0] CMD_READ = 2'd0;
    localparam logic [1:0] CMD_ZERO = 2'd1;
    localparam logic [1:0] CMD_BYTE = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    // Bytes on the SPI link.
    localparam logic [7:0] BYTE_READ = 8'h10;
    localparam logic [7:0] BYTE_NOP  = 8'h00;
    localparam logic [7:0] BYTE_ZERO = 8'h70;
    localparam logic [7:0] BYTE_ZACK = 8'h80;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // Turn arithmetic in counts of 1/4096 turn.
    localparam logic signed [12:0] HALF_TURN = 13'sd2048;
    localparam logic [31:0]        FULL_TURN = 32'd4096;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_READ_OK   = 3'd1,
        ST_READ_TOUT = 3'd2,
        ST_ZERO_OK   = 3'd3,
        ST_ZERO_TOUT = 3'd4
    } t_status;

endpackage

`default_nettype wire

// ===== design/spi_encoder_reader_unwrap_core.sv =====
// Top level of the SPI encoder reader: input register, sequencer, result register.
// Depends on spienc_pkg, spienc_unwrap and spi_encoder_reader_unwrap_core_macros.svh.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  in       | i_in_valid / o_in_ready    | i_cmd, i_channel, i_rx_byte
//  out      | o_out_valid / i_out_ready  | o_tx_valid, o_tx_byte, o_status,
//           |                            | o_out_channel, o_raw_position, o_turn_position
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A transaction is taken into the input register, processed there once the output register
// can take a result, and its result, if any, placed in the output register.
// One transaction is accepted per cycle while the output is not stalled; the sequencer
// state and channel unwrap registers update when it is processed, so the next one sees them.
// A stalled output holds the processing stage, and the input register fills behind it.
// Reset is synchronous and active low; the configuration port is always ready.
`default_nettype none
`include "spi_encoder_reader_unwrap_core_macros.svh"

module spi_encoder_reader_unwrap_core #(
    parameter int CHANNELS = spienc_pkg::CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input transactions.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_cmd,
    input  wire logic [1:0]                        i_channel,
    input  wire logic [7:0]                        i_rx_byte,
    // Result transactions.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_tx_valid,
    output logic [7:0]                             o_tx_byte,
    output logic [2:0]                             o_status,
    output logic [1:0]                             o_out_channel,
    output logic [11:0]                            o_raw_position,
    output logic signed [31:0]                     o_turn_position,
    // Configuration writes.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [spienc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                       i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RD_CMD  = 3'd1,
        PH_RD_ECHO = 3'd2,
        PH_RD_MSB  = 3'd3,
        PH_RD_LSB  = 3'd4,
        PH_Z_CMD   = 3'd5,
        PH_Z_WAIT  = 3'd6
    } t_phase;

    // Configuration registers.
    logic [15:0] r_read_tout;
    logic [15:0] r_zero_tout;

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [1:0]  r_in_channel;
    logic [7:0]  r_in_rx;

    // Sequencer state.
    t_phase      r_phase,   n_phase;
    logic [1:0]  r_active,  n_active;
    logic [15:0] r_elapsed, n_elapsed;
    logic [3:0]  r_nibble,  n_nibble;

    // Result register.
    logic        r_out_valid;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic [2:0]  r_status;
    logic [1:0]  r_out_channel;
    logic [11:0] r_raw;
    logic signed [31:0] r_turn;

    // Processing stage signals.
    logic        proc_en;
    logic        ch_ok;
    logic [16:0] tick_next;
    logic [11:0] raw;
    logic        unwrap_upd;
    logic signed [31:0] unwrap_turn;
    logic        res_valid;
    logic        res_txv;
    logic [7:0]  res_txb;
    spienc_pkg::t_status res_status;
    logic        res_pos;

    assign proc_en     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc_en;
    assign o_cfg_ready = 1'b1;

    assign ch_ok     = (int'(r_in_channel) < CHANNELS);
    assign tick_next = {1'b0, r_elapsed} + 17'd1;
    assign raw       = {r_nibble, r_in_rx};

    // Next sequencer state and the result of the transaction in the input register.
    always_comb begin
        n_phase    = r_phase;
        n_active   = r_active;
        n_elapsed  = r_elapsed;
        n_nibble   = r_nibble;
        res_valid  = 1'b0;
        res_txv    = 1'b0;
        res_txb    = spienc_pkg::BYTE_NOP;
        res_status = spienc_pkg::ST_BUSY;
        res_pos    = 1'b0;
        case (r_in_cmd)
            spienc_pkg::CMD_READ, spienc_pkg::CMD_ZERO: begin
                if (ch_ok) begin
                    n_active  = r_in_channel;
                    n_elapsed = '0;
                    n_nibble  = '0;
                    res_valid = 1'b1;
                    res_txv   = 1'b1;
                    if (r_in_cmd == spienc_pkg::CMD_READ) begin
                        n_phase = PH_RD_CMD;
                        res_txb = spienc_pkg::BYTE_READ;
                    end else begin
                        n_phase = PH_Z_CMD;
                        res_txb = spienc_pkg::BYTE_ZERO;
                    end
                end
            end
            spienc_pkg::CMD_BYTE: begin
                case (r_phase)
                    PH_RD_CMD: begin
                        n_phase   = PH_RD_ECHO;
                        res_valid = 1'b1;
                        res_txv   = 1'b1;
                    end
                    PH_RD_ECHO: begin
                        if (r_in_rx == spienc_pkg::BYTE_READ) begin
                            n_phase = PH_RD_MSB;
                        end
                        res_valid = 1'b1;
                        res_txv   = 1'b1;
                    end
                    PH_RD_MSB: begin
                        n_nibble  = r_in_rx[3:0] & spienc_pkg::NIBBLE_MASK;
                        n_phase   = PH_RD_LSB;
                        res_valid = 1'b1;
                        res_txv   = 1'b1;
                    end
                    PH_RD_LSB: begin
                        n_phase = PH_IDLE;
                        if (int'(r_active) < CHANNELS) begin
                            res_valid  = 1'b1;
                            res_status = spienc_pkg::ST_READ_OK;
                            res_pos    = 1'b1;
                        end
                    end
                    PH_Z_CMD: begin
                        n_phase   = PH_Z_WAIT;
                        res_valid = 1'b1;
                        res_txv   = 1'b1;
                    end
                    PH_Z_WAIT: begin
                        res_valid = 1'b1;
                        if (r_in_rx == spienc_pkg::BYTE_ZACK) begin
                            n_phase    = PH_IDLE;
                            res_status = spienc_pkg::ST_ZERO_OK;
                        end else begin
                            res_txv = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                // One millisecond tick: only the read command and echo phases and the zero phases count it.
                if (r_phase == PH_RD_CMD || r_phase == PH_RD_ECHO) begin
                    if (tick_next > {1'b0, r_read_tout}) begin
                        n_phase    = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = spienc_pkg::ST_READ_TOUT;
                    end else begin
                        n_elapsed = tick_next[15:0];
                    end
                end else if (r_phase == PH_Z_CMD || r_phase == PH_Z_WAIT) begin
                    if (tick_next >= {1'b0, r_zero_tout}) begin
                        n_phase    = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = spienc_pkg::ST_ZERO_TOUT;
                    end else begin
                        n_elapsed = tick_next[15:0];
                    end
                end
            end
        endcase
    end

    assign unwrap_upd = proc_en && res_pos;

    spienc_unwrap #(
        .CHANNELS (CHANNELS)
    ) u_unwrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (unwrap_upd),
        .i_channel (r_active),
        .i_raw     (raw),
        .o_turn    (unwrap_turn)
    );

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_tout <= spienc_pkg::READ_TIMEOUT_RST;
            r_zero_tout <= spienc_pkg::ZERO_TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == spienc_pkg::CFG_READ_TIMEOUT) begin
                r_read_tout <= i_cfg_data;
            end else if (i_cfg_index == spienc_pkg::CFG_ZERO_TIMEOUT) begin
                r_zero_tout <= i_cfg_data;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd     <= i_cmd;
            r_in_channel <= i_channel;
            r_in_rx      <= i_rx_byte;
        end
    end

    // Sequencer state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_active      <= '0;
            r_elapsed     <= '0;
            r_nibble      <= '0;
            r_out_valid   <= 1'b0;
            r_tx_valid    <= 1'b0;
            r_tx_byte     <= spienc_pkg::BYTE_NOP;
            r_status      <= spienc_pkg::ST_BUSY;
            r_out_channel <= '0;
            r_raw         <= '0;
            r_turn        <= '0;
        end else if (proc_en) begin
            r_phase       <= n_phase;
            r_active      <= n_active;
            r_elapsed     <= n_elapsed;
            r_nibble      <= n_nibble;
            r_out_valid   <= res_valid;
            r_tx_valid    <= res_txv;
            r_tx_byte     <= res_txv ? res_txb : spienc_pkg::BYTE_NOP;
            r_status      <= res_status;
            r_out_channel <= n_active;
            r_raw         <= res_pos ? raw : '0;
            r_turn        <= res_pos ? unwrap_turn : '0;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_valid      = r_tx_valid;
    assign o_tx_byte       = r_tx_byte;
    assign o_status        = r_status;
    assign o_out_channel   = r_out_channel;
    assign o_raw_position  = r_raw;
    assign o_turn_position = r_turn;

    // A finished operation never asks for another exchange.
    `SPIENC_ASSERT_SAME(a_done_no_tx,
        o_out_valid && (o_status != spienc_pkg::ST_BUSY),
        !o_tx_valid,
        "finished result requests a byte exchange")

    // Position fields are zero except on a successful read.
    `SPIENC_ASSERT_SAME(a_pos_only_read_ok,
        o_out_valid && (o_status != spienc_pkg::ST_READ_OK),
        (o_raw_position == '0) && (o_turn_position == '0),
        "position reported without a read")

    // A byte or tick while idle leaves the sequencer idle.
    `SPIENC_ASSERT_NEXT(a_idle_stays,
        proc_en && (r_phase == PH_IDLE) &&
        ((r_in_cmd == spienc_pkg::CMD_BYTE) || (r_in_cmd == spienc_pkg::CMD_TICK)),
        r_phase == PH_IDLE,
        "idle sequencer left idle without a start")

endmodule

`default_nettype wire

// ===== design/spienc_unwrap.sv =====
// Per-channel multi-turn unwrapping: previous raw position and turn offset.
// Depends on spienc_pkg for the turn constants.
`default_nettype none

module spienc_unwrap #(
    parameter int CHANNELS = spienc_pkg::CHANNELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_upd,
    input  wire logic [1:0]         i_channel,
    input  wire logic [11:0]        i_raw,
    output logic signed [31:0]      o_turn
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [11:0]       r_last_raw [CHANNELS];
    logic [31:0]       r_offset   [CHANNELS];
    logic [CH_W-1:0]   idx;
    logic signed [12:0] dif;
    logic [31:0]       n_offset;

    assign idx = CH_W'(i_channel);

    // Jump from the previous raw position, and the offset it implies.
    always_comb begin
        dif = $signed({1'b0, i_raw}) - $signed({1'b0, r_last_raw[idx]});
        if (dif > spienc_pkg::HALF_TURN) begin
            n_offset = r_offset[idx] - spienc_pkg::FULL_TURN;
        end else if (dif < -spienc_pkg::HALF_TURN) begin
            n_offset = r_offset[idx] + spienc_pkg::FULL_TURN;
        end else begin
            n_offset = r_offset[idx];
        end
    end

    assign o_turn = $signed(n_offset + {20'd0, i_raw});

    // Channel state is updated once the second position byte arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_last_raw[k] <= '0;
                r_offset[k]   <= '0;
            end
        end else if (i_upd) begin
            r_last_raw[idx] <= i_raw;
            r_offset[idx]   <= n_offset;
        end
    end

endmodule

`default_nettype wire
